[rtl/core/pcm_channel_extractor_top_defines.svh]
// ----------------------------------------------------------------------------
// pcm_channel_extractor_top_defines
// Assertion macros shared by the extractor RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PCM_CHANNEL_EXTRACTOR_TOP_DEFINES_SVH
`define PCM_CHANNEL_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define PCE_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define PCE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PCE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PCE_ASSERT(label, cond, msg)
`define PCE_ASSERT_IMP(label, ante, cons, msg)
`define PCE_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[rtl/core/pce_pkg.sv]
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and constants of the PCM channel extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CHANNELS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHANNEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES       = 3'd5;
    localparam int CFG_DATA_W = 7;

    // source width codes
    localparam logic [1:0] SW_8  = 2'd0;
    localparam logic [1:0] SW_16 = 2'd1;
    localparam logic [1:0] SW_24 = 2'd2;
    localparam logic [1:0] SW_32 = 2'd3;

    // output width codes
    localparam logic [2:0] OW_SAME = 3'd0;
    localparam logic [2:0] OW_8    = 3'd1;
    localparam logic [2:0] OW_32   = 3'd4;

    typedef struct packed {
        logic [4:0] source_channels;
        logic [1:0] source_width_code;
        logic [2:0] output_width_code;
        logic [3:0] first_channel;
        logic [4:0] channel_count;
        logic [6:0] frame_bytes;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        source_channels:   5'd2,
        source_width_code: SW_16,
        output_width_code: OW_SAME,
        first_channel:     4'd0,
        channel_count:     5'd1,
        frame_bytes:       7'd4
    };

    // one sample (or one passed byte) waiting to be sent out
    typedef struct packed {
        logic [31:0]       raw;       // gathered little-endian sample
        logic signed [2:0] offs;      // source minus output bytes
        logic [1:0]        cnt_m1;    // output bytes minus one
        logic [3:0]        channel;
        logic              group_end; // set when the sample closes the group
    } job_t;

    localparam int JOB_DEPTH = 4;

endpackage

`default_nettype wire

[rtl/core/pce_front.sv]
// ----------------------------------------------------------------------------
// pce_front
// Frame position tracking, channel selection and sample gathering.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_front
    import pce_pkg::*;
#(
    parameter int MAX_CHANNELS    = 16,
    parameter int MAX_FRAME_BYTES = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       frame_start,
    output logic            job_push,
    output job_t            job
);

    localparam int FB_LIM = (MAX_FRAME_BYTES > 127) ? 127 : MAX_FRAME_BYTES;
    localparam int POS_W  = (FB_LIM > 1) ? $clog2(FB_LIM) : 1;
    localparam logic [6:0] FB_CAP = 7'(FB_LIM);
    localparam int SC_LIM = (MAX_CHANNELS > 31) ? 31 : MAX_CHANNELS;
    localparam logic [4:0] SC_CAP = 5'(SC_LIM);
    // floor(x / 3) = (x * 171) >> 9 for x below 128
    localparam logic [14:0] DIV3_MUL = 15'd171;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [31:0]      acc_reg;
    logic [31:0]      acc_next;

    logic [6:0]  fb_eff;
    logic [4:0]  sc_eff;
    logic [6:0]  pos;
    logic [6:0]  nxt;
    logic [14:0] prod3;
    logic [6:0]  ch;
    logic [1:0]  bi;
    logic [2:0]  sb;
    logic [2:0]  ob;
    logic [5:0]  grp_hi;
    logic        range_ok;
    logic        keep;
    logic        pass;
    logic [8:0]  ge_pos;
    logic [31:0] acc_base;
    logic [31:0] acc_merged;

    always_comb
    begin
        fb_eff = (cfg.frame_bytes == 7'd0) ? 7'd1 : cfg.frame_bytes;
        if (fb_eff > FB_CAP)
        begin
            fb_eff = FB_CAP;
        end
        sc_eff = (cfg.source_channels > SC_CAP) ? SC_CAP : cfg.source_channels;

        pos = frame_start ? 7'd0 : 7'(pos_reg);
        if (pos >= fb_eff)
        begin
            pos = 7'd0;
        end
        nxt = pos + 7'd1;
        if (nxt >= fb_eff)
        begin
            nxt = 7'd0;
        end

        // channel and byte-in-sample from the frame position
        prod3 = 15'(pos) * DIV3_MUL;
        case (cfg.source_width_code)
            SW_8:
            begin
                ch = pos;
                bi = 2'd0;
            end
            SW_16:
            begin
                ch = {1'b0, pos[6:1]};
                bi = {1'b0, pos[0]};
            end
            SW_24:
            begin
                ch = {1'b0, prod3[14:9]};
                bi = 2'(pos - ch - {ch[5:0], 1'b0});
            end
            SW_32:
            begin
                ch = {2'b00, pos[6:2]};
                bi = pos[1:0];
            end
            default:
            begin
                ch = pos;
                bi = 2'd0;
            end
        endcase

        sb = {1'b0, cfg.source_width_code} + 3'd1;
        ob = (cfg.output_width_code inside {[OW_8:OW_32]}) ? cfg.output_width_code : sb;
        pass = (ob == sb);

        grp_hi   = {2'b00, cfg.first_channel} + {1'b0, cfg.channel_count};
        range_ok = (cfg.channel_count != 5'd0) && (sc_eff != 5'd0)
                   && (grp_hi <= {1'b0, sc_eff});
        keep     = range_ok && (ch >= 7'(cfg.first_channel)) && (ch < 7'(grp_hi));
        ge_pos   = 9'(grp_hi) * 9'(sb) - 9'd1;

        acc_base   = (bi == 2'd0) ? 32'd0 : acc_reg;
        acc_merged = acc_base | (32'(in_byte) << {bi, 3'b000});

        job.raw       = pass ? 32'(in_byte) : acc_merged;
        job.offs      = pass ? 3'sd0 : $signed(sb - ob);
        job.cnt_m1    = pass ? 2'd0 : 2'(ob - 3'd1);
        job.channel   = ch[3:0];
        job.group_end = pass ? (9'(pos) == ge_pos) : (ch == 7'(grp_hi - 6'd1));

        job_push = accept && keep && (pass || (bi == cfg.source_width_code));
        acc_next = (accept && keep && !pass) ? acc_merged : acc_reg;
        pos_next = accept ? POS_W'(nxt) : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pce_job_fifo.sv]
// ----------------------------------------------------------------------------
// pce_job_fifo
// Short register queue of samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pcm_channel_extractor_top_defines.svh"

module pce_job_fifo
    import pce_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_data,
    input  wire logic rd_en,
    output job_t      rd_data,
    output logic      full,
    output logic      not_empty
);

    localparam int PTR_W = $clog2(JOB_DEPTH);

    job_t             mem_reg [JOB_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full      = (count_reg == (PTR_W+1)'(JOB_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `PCE_ASSERT(a_fifo_no_overflow, count_reg <= (PTR_W+1)'(JOB_DEPTH), "job queue overflow")
    `PCE_ASSERT_IMP(a_fifo_wr_not_full, wr_en, !full, "write into full job queue")
    `PCE_ASSERT_NXT(a_fifo_fill, wr_en && !rd_en, count_reg == $past(count_reg) + 1'b1,
                    "job queue count did not grow on write")

endmodule

`default_nettype wire

[rtl/core/pce_back.sv]
// ----------------------------------------------------------------------------
// pce_back
// Sends the head sample out one byte per pop, after the width shift.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pcm_channel_extractor_top_defines.svh"

module pce_back
    import pce_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire job_t  head,
    input  wire logic  head_valid,
    input  wire logic  pop,
    output logic       deq,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic [3:0] out_channel,
    output logic       group_end,
    output logic       last
);

    logic [1:0]        k_reg;
    logic [1:0]        k_next;
    logic signed [3:0] idx;
    logic              fin;

    always_comb
    begin
        // byte k of the shifted sample is byte k + offs of the raw sample
        idx = $signed({2'b00, k_reg}) + $signed({head.offs[2], head.offs});
        case (idx)
            4'sd0:   out_byte = head.raw[7:0];
            4'sd1:   out_byte = head.raw[15:8];
            4'sd2:   out_byte = head.raw[23:16];
            4'sd3:   out_byte = head.raw[31:24];
            default: out_byte = 8'd0;
        endcase

        fin         = (k_reg == head.cnt_m1);
        empty       = !head_valid;
        out_channel = head.channel;
        last        = fin;
        group_end   = fin && head.group_end;
        deq         = pop && head_valid && fin;

        k_next = k_reg;
        if (pop && head_valid)
        begin
            k_next = fin ? 2'd0 : k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    `PCE_ASSERT_IMP(a_back_idle_k, !head_valid, k_reg == 2'd0, "byte index set with no sample")
    `PCE_ASSERT_IMP(a_back_k_range, head_valid, k_reg <= head.cnt_m1,
                    "byte index past end of sample")

endmodule

`default_nettype wire

[rtl/core/pcm_channel_extractor_top.sv]
// ----------------------------------------------------------------------------
// pcm_channel_extractor_top
// Picks a group of consecutive channels out of an interleaved PCM byte stream.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  --------------------------------------------
//  input     push / full          in_byte[7:0], frame_start
//  result    empty / pop          out_byte[7:0], out_channel[3:0], group_end,
//                                 last
//  config    cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[6:0]
//
//  One input item is taken every cycle while full is low; a result byte leaves
//  every cycle while empty is low and pop is high.
//  Throughput is set by the result port: a widening sample turns one input
//  item into up to four result items, sent one per popped cycle from the job queue.
//  A result is queued with its last source byte and shown from the queue head.
//  full depends only on the four-entry job queue, never on pop in the same
//  cycle. Reset loads the default configuration and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_channel_extractor_top
    import pce_pkg::*;
#(
    parameter int MAX_CHANNELS    = 16,
    parameter int MAX_FRAME_BYTES = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // source byte stream
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  frame_start,
    // extracted bytes
    output logic                       empty,
    input  wire logic                  pop,
    output logic [7:0]                 out_byte,
    output logic [3:0]                 out_channel,
    output logic                       group_end,
    output logic                       last,
    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic accept;
    logic job_push;
    job_t job;
    job_t head;
    logic head_valid;
    logic deq;

    // registers take writes at any time; the user only writes while idle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SOURCE_CHANNELS:   cfg_next.source_channels   = cfg_data[4:0];
                REG_SOURCE_WIDTH_CODE: cfg_next.source_width_code = cfg_data[1:0];
                REG_OUTPUT_WIDTH_CODE: cfg_next.output_width_code = cfg_data[2:0];
                REG_FIRST_CHANNEL:     cfg_next.first_channel     = cfg_data[3:0];
                REG_CHANNEL_COUNT:     cfg_next.channel_count     = cfg_data[4:0];
                REG_FRAME_BYTES:       cfg_next.frame_bytes       = cfg_data[6:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // an item is taken whenever the queue has room, whether or not it yields
    // a sample; this keeps full free of any decode of the incoming byte
    assign accept = push && !full;

    // front: position, channel filter, sample gathering
    pce_front #(
        .MAX_CHANNELS    (MAX_CHANNELS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .in_byte     (in_byte),
        .frame_start (frame_start),
        .job_push    (job_push),
        .job         (job)
    );

    // decouples the byte-per-cycle front from the byte-per-pop back
    pce_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (job_push),
        .wr_data   (job),
        .rd_en     (deq),
        .rd_data   (head),
        .full      (full),
        .not_empty (head_valid)
    );

    // back: width shift and byte serialization
    pce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .deq         (deq),
        .empty       (empty),
        .out_byte    (out_byte),
        .out_channel (out_channel),
        .group_end   (group_end),
        .last        (last)
    );

endmodule

`default_nettype wire

[tb/sv/pcm_channel_extractor_top_tb.sv]
// ----------------------------------------------------------------------------
// pcm_channel_extractor_top_tb
// Self-checking bench for the PCM channel extractor. Byte frames go in under
// many channel and width settings, and each output item is checked against a
// built-in predictor of the extractor.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_channel_extractor_top_tb
    import pce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Output width codes the package leaves unnamed.
    localparam logic [2:0] OW_16 = 3'd2;
    localparam logic [2:0] OW_24 = 3'd3;

    localparam int LIMIT_CHANNELS    = 16;
    localparam int LIMIT_FRAME_BYTES = 64;
    localparam int ITEM_TARGET       = 250;  // input items to send; the last frames may run past it
    localparam int HOLD_CYCLES       = 200;  // long receiver stall
    localparam int SETTLE_CYCLES     = 8;    // wait for results still in flight after the last byte

    // One byte as it should leave the result port.
    typedef struct {
        logic [7:0] data;
        logic [3:0] chan;
        logic       grp_end;
        logic       lst;
    } out_byte_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks frame position and the sample being gathered, turns
    // every accepted input item into the output items it should cause, and
    // checks output items in order.
    // ------------------------------------------------------------------------
    class extract_scoreboard;
        cfg_t        regs;
        int unsigned frame_pos;
        logic [31:0] gathered;
        out_byte_t   awaited_bytes[$];
        int          errors;

        function new();
            regs      = CFG_RESET;
            frame_pos = 0;
            gathered  = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_SOURCE_CHANNELS:   regs.source_channels   = d[4:0];
                REG_SOURCE_WIDTH_CODE: regs.source_width_code = d[1:0];
                REG_OUTPUT_WIDTH_CODE: regs.output_width_code = d[2:0];
                REG_FIRST_CHANNEL:     regs.first_channel     = d[3:0];
                REG_CHANNEL_COUNT:     regs.channel_count     = d[4:0];
                REG_FRAME_BYTES:       regs.frame_bytes       = d[6:0];
                default: ;
            endcase
        endfunction

        function void add_awaited(logic [7:0] d, int unsigned ch, bit ge, bit lst);
            out_byte_t o;
            o.data    = d;
            o.chan    = ch[3:0];
            o.grp_end = ge;
            o.lst     = lst;
            awaited_bytes = {awaited_bytes, o};
        endfunction

        function void note_source_byte(logic [7:0] b, logic fs);
            int unsigned fb, sc, sb, ob, fc, cc, pos, ch, bi, lo, hi;
            logic [31:0] smp;
            fb = regs.frame_bytes;
            sc = regs.source_channels;
            fc = regs.first_channel;
            cc = regs.channel_count;
            sb = regs.source_width_code + 1;
            if (fb == 0) fb = 1;
            if (fb > LIMIT_FRAME_BYTES) fb = LIMIT_FRAME_BYTES;
            if (sc > LIMIT_CHANNELS) sc = LIMIT_CHANNELS;
            // code 0 and codes past 32 bits fall back to the source width
            if (regs.output_width_code >= OW_8 && regs.output_width_code <= OW_32)
                ob = regs.output_width_code;
            else
                ob = sb;

            pos = fs ? 0 : frame_pos;
            if (pos >= fb) pos = 0;
            ch = pos / sb;
            bi = pos % sb;
            frame_pos = (pos + 1 >= fb) ? 0 : pos + 1;

            lo = fc;
            hi = fc + cc;
            if (cc == 0 || sc == 0 || hi > sc || ch < lo || ch >= hi)
                return;

            if (ob == sb)
            begin
                add_awaited(b, ch, pos == hi * sb - 1, 1'b1);
                return;
            end

            if (bi == 0) gathered = '0;
            gathered |= 32'(b) << (8 * bi);
            if (bi == sb - 1)
            begin
                smp = gathered;
                if (ob > sb) smp = smp << (8 * (ob - sb));
                else         smp = smp >> (8 * (sb - ob));
                for (int unsigned k = 0; k < ob; k++)
                    add_awaited(smp[8*k +: 8], ch, (k == ob - 1) && (ch == hi - 1),
                                k == ob - 1);
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            errors++;
        endtask

        task check_output_byte(logic [7:0] d, logic [3:0] ch, logic ge, logic lst);
            out_byte_t want;
            if (awaited_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item byte=%02h ch=%0d", d, ch));
                return;
            end
            want = awaited_bytes[0];
            awaited_bytes.delete(0);
            if (d !== want.data)
                report_mismatch($sformatf("out_byte %02h, want %02h", d, want.data));
            if (ch !== want.chan)
                report_mismatch($sformatf("out_channel %0d, want %0d", ch, want.chan));
            if (ge !== want.grp_end)
                report_mismatch($sformatf("group_end %b, want %b", ge, want.grp_end));
            if (lst !== want.lst)
                report_mismatch($sformatf("last %b, want %b", lst, want.lst));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    logic [7:0]            in_byte     = '0;
    logic                  frame_start = 1'b0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [7:0]            out_byte;
    logic [3:0]            out_channel;
    logic                  group_end;
    logic                  last;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    pcm_channel_extractor_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .frame_start (frame_start),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .out_channel (out_channel),
        .group_end   (group_end),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    extract_scoreboard sb = new();

    int send_idle_pct = 9;   // chance of a gap after each accepted item
    int rcv_idle_pct  = 72;  // chance pop stays low in a cycle
    int items_sent    = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Receiver. pop changes on the falling edge. A long hold-off is asked for
    // by the stimulus through hold_req and counted down here.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Output items are taken at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_output_byte(out_byte, out_channel, group_end, last);
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one byte and hold it until full is seen low at a rising edge.
    // A random gap may follow, so idles land at any point in a frame.
    task automatic send_byte(logic [7:0] b, logic fs);
        @(negedge clk);
        push        <= 1'b1;
        in_byte     <= b;
        frame_start <= fs;
        do @(posedge clk); while (full !== 1'b0);
        sb.note_source_byte(b, fs);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
    endtask

    // Stop offering and let every awaited item drain, then wait SETTLE_CYCLES for a
    // sample that may still be in flight without a result.
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.awaited_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, d);
    endtask

    // Full register set, always written with the block idle.
    task automatic apply_setup(logic [4:0] sc, logic [1:0] sw, logic [2:0] ow,
                               logic [3:0] fc, logic [4:0] cc, logic [6:0] fb);
        wait_idle();
        write_reg(REG_SOURCE_CHANNELS,   CFG_DATA_W'(sc));
        write_reg(REG_SOURCE_WIDTH_CODE, CFG_DATA_W'(sw));
        write_reg(REG_OUTPUT_WIDTH_CODE, CFG_DATA_W'(ow));
        write_reg(REG_FIRST_CHANNEL,     CFG_DATA_W'(fc));
        write_reg(REG_CHANNEL_COUNT,     CFG_DATA_W'(cc));
        write_reg(REG_FRAME_BYTES,       fb);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small, well-formed layouts; now and then anything the register
    // widths allow (zero or oversized counts, bad ranges, long frames).
    task automatic random_setup(output int frame_len);
        logic [4:0] sc;
        logic [1:0] sw;
        logic [2:0] ow;
        logic [3:0] fc;
        logic [4:0] cc;
        logic [6:0] fb;
        sw = 2'($urandom_range(3));
        ow = 3'($urandom_range(7));
        if ($urandom_range(99) < 80)
        begin
            sc = 5'($urandom_range(1, 4));
            cc = 5'($urandom_range(1, sc));
            fc = 4'($urandom_range(0, sc - cc));
            fb = 7'(sc * (sw + 1) + $urandom_range(0, 2));
        end
        else
        begin
            sc = 5'($urandom_range(31));
            cc = 5'($urandom_range(31));
            fc = 4'($urandom_range(15));
            fb = 7'($urandom_range(127));
        end
        frame_len = (fb == 0) ? 1 : (fb > LIMIT_FRAME_BYTES) ? LIMIT_FRAME_BYTES : fb;
        apply_setup(sc, sw, ow, fc, cc, fb);
    endtask

    // Frames of random content. Most carry frame_start on byte 0; some rely
    // on the position counter alone; a few are cut short with stray markers.
    task automatic send_frames(int frame_len, int nframes);
        int shape;
        int len;
        for (int f = 0; f < nframes; f++)
        begin
            shape = $urandom_range(99);
            len   = (shape >= 90) ? $urandom_range(1, frame_len) : frame_len;
            for (int i = 0; i < len; i++)
            begin
                if (shape < 80)
                    send_byte(8'($urandom_range(255)), i == 0);
                else if (shape < 90)
                    send_byte(8'($urandom_range(255)), 1'b0);
                else
                    send_byte(8'($urandom_range(255)),
                              (i == 0) || ($urandom_range(99) < 20));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int flen;
        int rnd_base;
        int span;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: 2 channels of 16 bits, channel 0 passed through.
        // Extreme byte values, then a frame_start that realigns mid-frame.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        send_byte(8'h78, 1'b0);

        // Group runs past the last channel: nothing comes out.
        apply_setup(5'd2, SW_16, OW_SAME, 4'd1, 5'd2, 7'd4);
        repeat (4) send_byte(8'($urandom_range(255)), 1'b0);

        // Narrowest source widened to 32 bits, one-byte frames.
        apply_setup(5'd1, SW_8, OW_32, 4'd0, 5'd1, 7'd1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);

        // Frame length zero acts as one; unused output code means same width.
        apply_setup(5'd1, SW_24, 3'd7, 4'd0, 5'd1, 7'd0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);

        // 24 to 16 bit narrowing on channels 1 and 2, one pad byte.
        apply_setup(5'd3, SW_24, OW_16, 4'd1, 5'd2, 7'd10);
        send_frames(10, 1);

        // Pressure: all 16 channels widened 8 to 32 bits, four items per
        // byte, while the receiver stalls. The job queue fills and full
        // must hold the sender back until pop resumes.
        apply_setup(5'd16, SW_8, OW_32, 4'd0, 5'd16, 7'd16);
        hold_req = 1'b1;
        send_frames(16, 2);

        // Random part. First frame at the largest layout: oversized channel
        // count and frame length saturate, last channel narrowed to 8 bits.
        rnd_base = items_sent;
        span     = ITEM_TARGET - rnd_base;
        apply_setup(5'd31, SW_32, OW_8, 4'd15, 5'd1, 7'd127);
        send_frames(LIMIT_FRAME_BYTES, 1);
        while (items_sent < ITEM_TARGET)
        begin
            // idle mix: slow receiver, then slow sender, then full rate
            if (items_sent - rnd_base < span / 3)
            begin
                send_idle_pct = 9;
                rcv_idle_pct  = 72;
            end
            else if (items_sent - rnd_base < 2 * span / 3)
            begin
                send_idle_pct = 72;
                rcv_idle_pct  = 9;
            end
            else
            begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
            end
            random_setup(flen);
            send_frames(flen, $urandom_range(1, 4));
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.awaited_bytes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
